[hw/rtl/sos_pkg.sv]
// Shared types and constants for the script opcode scanner.
package sos_pkg;

  localparam logic [23:0] MAX24 = 24'hFF_FFFF;

  localparam logic [7:0] OP_0          = 8'h00;
  localparam logic [7:0] OP_PUSH_LEN1  = 8'h4C;
  localparam logic [7:0] OP_PUSH_LEN2  = 8'h4D;
  localparam logic [7:0] OP_PUSH_LEN4  = 8'h4E;
  localparam logic [7:0] OP_1          = 8'h51;
  localparam logic [7:0] OP_16         = 8'h60;
  localparam logic [7:0] OP_DATA_MARK  = 8'h6A;
  localparam logic [7:0] OP_SIGCHK     = 8'hAC;
  localparam logic [7:0] OP_SIGCHK_VFY = 8'hAD;
  localparam logic [7:0] OP_MULTISIG   = 8'hAE;
  localparam logic [7:0] OP_MULTISIGV  = 8'hAF;
  localparam logic [7:0] OP_LAST_NOP   = 8'hB9;
  localparam logic [7:0] OP_INVALID    = 8'hFF;
  localparam logic [7:0] SMALLNUM_BIAS = 8'h50;

  localparam logic [23:0] WP_MIN_LEN = 24'd4;
  localparam logic [23:0] WP_MAX_LEN = 24'd42;
  localparam logic [23:0] WP_HDR_LEN = 24'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCURATE_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTISIG_KEY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEMENT_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCRIPT_BYTES   = 3'd3;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] script_byte;
    logic       has_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [23:0] sigop_count;
    logic        parse_ok;
    logic        push_only;
    logic        valid_ops;
    logic        unspendable;
    logic        witness_program;
    logic [4:0]  witness_version;
    logic [23:0] script_length;
  } out_t;

  typedef struct packed {
    logic        accurate_count;
    logic [7:0]  multisig_key_limit;
    logic [15:0] max_element_bytes;
    logic [23:0] max_script_bytes;
  } cfg_t;

endpackage

[hw/rtl/sos_core.sv]
// Per-script parse state and end-of-script result logic.
module sos_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  sos_pkg::in_t  item,
  input  sos_pkg::cfg_t cfg,
  output sos_pkg::out_t res
);

  sos_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [31:0] plen_r, plen_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [23:0] sig_r, sig_nxt;
  logic [23:0] bt_r, bt_nxt;
  logic [15:0] ftb_r, ftb_nxt;
  logic        pushonly_r, pushonly_nxt;
  logic        valid_r, valid_nxt;

  logic        do_push;
  logic [31:0] push_size;
  logic        add_en;
  logic [7:0]  add_n;
  logic [24:0] sig_sum;
  logic [2:0]  len_total;
  logic [1:0]  len_idx;
  logic [7:0]  b;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        ok;
  logic        small_first;
  logic        wp;

  assign b = item.script_byte;

  always_comb begin
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    plen_nxt     = plen_r;
    rem_nxt      = rem_r;
    prev_nxt     = prev_r;
    sig_nxt      = sig_r;
    bt_nxt       = bt_r;
    ftb_nxt      = ftb_r;
    pushonly_nxt = pushonly_r;
    valid_nxt    = valid_r;
    do_push      = 1'b0;
    push_size    = 32'd0;
    add_en       = 1'b0;
    add_n        = 8'd0;
    sig_sum      = 25'd0;
    len_total    = 3'd4;
    len_idx      = 2'd0;

    if (item.has_byte) begin
      if (bt_r == 24'd0) begin
        ftb_nxt[7:0] = b;
      end else if (bt_r == 24'd1) begin
        ftb_nxt[15:8] = b;
      end
      if (bt_r != sos_pkg::MAX24) begin
        bt_nxt = bt_r + 24'd1;
      end

      case (phase_r)
        sos_pkg::PH_LENGTH: begin
          if (prev_r == sos_pkg::OP_PUSH_LEN1) begin
            len_total = 3'd1;
          end else if (prev_r == sos_pkg::OP_PUSH_LEN2) begin
            len_total = 3'd2;
          end else begin
            len_total = 3'd4;
          end
          len_idx  = 2'(len_total - left_r);
          plen_nxt = plen_r | ({24'd0, b} << {len_idx, 3'b000});
          left_nxt = (left_r == 3'd0) ? 3'd0 : left_r - 3'd1;
          if (left_nxt == 3'd0) begin
            do_push   = 1'b1;
            push_size = plen_nxt;
          end
        end
        sos_pkg::PH_DATA: begin
          rem_nxt = (rem_r == 32'd0) ? 32'd0 : rem_r - 32'd1;
          if (rem_nxt == 32'd0) begin
            phase_nxt = sos_pkg::PH_OPCODE;
          end
        end
        default: begin
          prev_nxt = b;
          if (b < sos_pkg::OP_PUSH_LEN1) begin
            do_push   = 1'b1;
            push_size = {24'd0, b};
          end else if (b <= sos_pkg::OP_PUSH_LEN4) begin
            phase_nxt = sos_pkg::PH_LENGTH;
            plen_nxt  = 32'd0;
            if (b == sos_pkg::OP_PUSH_LEN1) begin
              left_nxt = 3'd1;
            end else if (b == sos_pkg::OP_PUSH_LEN2) begin
              left_nxt = 3'd2;
            end else begin
              left_nxt = 3'd4;
            end
          end else begin
            if (b > sos_pkg::OP_16) begin
              pushonly_nxt = 1'b0;
            end
            if (b > sos_pkg::OP_LAST_NOP) begin
              valid_nxt = 1'b0;
            end
            if (b == sos_pkg::OP_SIGCHK || b == sos_pkg::OP_SIGCHK_VFY) begin
              add_en = 1'b1;
              add_n  = 8'd1;
            end else if (b == sos_pkg::OP_MULTISIG || b == sos_pkg::OP_MULTISIGV) begin
              add_en = 1'b1;
              // exact count needs a small-number opcode right before
              if (cfg.accurate_count && prev_r >= sos_pkg::OP_1 &&
                  prev_r <= sos_pkg::OP_16) begin
                add_n = prev_r - sos_pkg::SMALLNUM_BIAS;
              end else begin
                add_n = cfg.multisig_key_limit;
              end
            end
          end
        end
      endcase

      if (do_push) begin
        if (push_size > {16'd0, cfg.max_element_bytes}) begin
          valid_nxt = 1'b0;
        end
        if (push_size == 32'd0) begin
          phase_nxt = sos_pkg::PH_OPCODE;
        end else begin
          phase_nxt = sos_pkg::PH_DATA;
          rem_nxt   = push_size;
        end
      end

      if (add_en) begin
        // saturate at the top of the 24-bit range
        sig_sum = {1'b0, sig_r} + {17'd0, add_n};
        sig_nxt = (sig_sum >= {1'b0, sos_pkg::MAX24}) ? sos_pkg::MAX24 : sig_sum[23:0];
      end
    end
  end

  always_comb begin
    b0          = ftb_nxt[7:0];
    b1          = ftb_nxt[15:8];
    ok          = (phase_nxt != sos_pkg::PH_LENGTH) && (phase_nxt != sos_pkg::PH_DATA);
    small_first = (b0 >= sos_pkg::OP_1) && (b0 <= sos_pkg::OP_16);
    wp          = (bt_nxt >= sos_pkg::WP_MIN_LEN) && (bt_nxt <= sos_pkg::WP_MAX_LEN) &&
                  ((b0 == sos_pkg::OP_0) || small_first) &&
                  (({16'd0, b1} + sos_pkg::WP_HDR_LEN) == bt_nxt);

    res.sigop_count     = sig_nxt;
    res.parse_ok        = ok;
    res.push_only       = ok & pushonly_nxt;
    res.valid_ops       = ok & valid_nxt;
    res.unspendable     = ((bt_nxt != 24'd0) && (b0 == sos_pkg::OP_DATA_MARK)) ||
                          (bt_nxt > cfg.max_script_bytes);
    res.witness_program = wp;
    res.witness_version = (wp && small_first) ? 5'(b0 - sos_pkg::SMALLNUM_BIAS) : 5'd0;
    res.script_length   = bt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && item.last_byte)) begin
      phase_r    <= sos_pkg::PH_OPCODE;
      left_r     <= 3'd0;
      plen_r     <= 32'd0;
      rem_r      <= 32'd0;
      prev_r     <= sos_pkg::OP_INVALID;
      sig_r      <= 24'd0;
      bt_r       <= 24'd0;
      ftb_r      <= 16'd0;
      pushonly_r <= 1'b1;
      valid_r    <= 1'b1;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      plen_r     <= plen_nxt;
      rem_r      <= rem_nxt;
      prev_r     <= prev_nxt;
      sig_r      <= sig_nxt;
      bt_r       <= bt_nxt;
      ftb_r      <= ftb_nxt;
      pushonly_r <= pushonly_nxt;
      valid_r    <= valid_nxt;
    end
  end

endmodule

[hw/rtl/script_op_scanner.sv]
// Top level of the script opcode scanner: config registers and result register.
//
//   channel  ports                                   direction
//   in       in_valid, in_stall, in_item (in_t)       byte stream in
//   out      out_valid, out_stall, out_item (out_t)   one result per script
//   cfg      cfg_we, cfg_index, cfg_data              register writes
//
// One item per cycle while in_stall is low: the parse state updates in the accept
// cycle and the result of a last_byte item sits in the output register from the next cycle.
// Synchronous active-low reset restores default config and clears the parser.
// in_stall rises only while a result waits in the output register under out_stall.
module script_op_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sos_pkg::in_t                       in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sos_pkg::out_t                      out_item,
  input  logic                               cfg_we,
  input  logic [sos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sos_pkg::CFG_DATA_W-1:0]     cfg_data
);

  sos_pkg::cfg_t cfg_r;
  sos_pkg::out_t res;
  sos_pkg::out_t out_item_r;
  logic          out_valid_r;
  logic          in_fire;
  logic          res_load;

  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign res_load  = in_fire & in_item.last_byte;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accurate_count     <= 1'b1;
      cfg_r.multisig_key_limit <= 8'd20;
      cfg_r.max_element_bytes  <= 16'd520;
      cfg_r.max_script_bytes   <= 24'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        sos_pkg::CFG_ACCURATE_COUNT:     cfg_r.accurate_count     <= cfg_data[0];
        sos_pkg::CFG_MULTISIG_KEY_LIMIT: cfg_r.multisig_key_limit <= cfg_data[7:0];
        sos_pkg::CFG_MAX_ELEMENT_BYTES:  cfg_r.max_element_bytes  <= cfg_data[15:0];
        sos_pkg::CFG_MAX_SCRIPT_BYTES:   cfg_r.max_script_bytes   <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  sos_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_fire),
    .item   (in_item),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      // drop the result once taken
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item_r <= res;
    end
  end

endmodule
